@@ rtl/core/jfifo_pkg.sv @@
// Shared types and constants for the job FIFO with indexed removal.
// Used by jfifo_cell and job_fifo_with_indexed_removal_top; no dependencies.
`timescale 1ns / 1ps

package jfifo_pkg;

  // Default number of job slots
  localparam int unsigned QueueDepthDefault = 16;

  // Field widths fixed by the interface
  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned HeldW  = 5;

  // Operation codes
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One job record
  typedef struct packed {
    logic [WordW-1:0] total_length;
    logic [WordW-1:0] front_length;
    logic [WordW-1:0] back_length;
    logic [WordW-1:0] quantity;
  } job_rec_t;

  // Per-cell control: load the pushed record, or take the neighbor's record
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

@@ rtl/core/jfifo_cell.sv @@
// One slot of the job chain: holds a record, loads a pushed record or
// takes the record of the next slot. Depends on jfifo_pkg.
`timescale 1ns / 1ps

module jfifo_cell (
  input  logic                clk_i,
  input  jfifo_pkg::cell_ctl_t ctl_i,
  input  jfifo_pkg::job_rec_t push_rec_i,
  input  jfifo_pkg::job_rec_t next_rec_i,
  output jfifo_pkg::job_rec_t rec_o
);

  jfifo_pkg::job_rec_t rec_q, rec_d;

  // Slot update: push has priority, then shift up from the neighbor
  always_comb begin
    rec_d = rec_q;
    if (ctl_i.load) begin
      rec_d = push_rec_i;
    end else if (ctl_i.shift) begin
      rec_d = next_rec_i;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

@@ rtl/core/job_fifo_with_indexed_removal_top.sv @@
// Top level of the job FIFO with indexed removal: count control, chain of
// job cells and registered result. Depends on jfifo_pkg and jfifo_cell.
`timescale 1ns / 1ps

// Usage:
//   A transaction is issued by raising start_i with op_i and its operands;
//   it is taken at the clock edge where start_i is high and busy_o is low.
//   busy_o stays low, so one operation can be issued in every cycle.
//   Operations: push at tail, pop from head, remove at position_i, clear.
//   Each operation produces exactly one result, shown for one cycle with
//   done_o high, in the cycle right after the operation is taken (throughput
//   one per cycle). The result holds the status, the popped record
//   (zero unless a pop succeeded), the count after the operation and an
//   empty flag.
//   Removal shifts every later slot up by one: each cell from the removed
//   position on, but the last, takes its neighbor's record in parallel; a
//   push loads the cell addressed by the count.
//   Reset empties the queue; slot contents are not cleared and are never
//   read before being written. The result channel has no back-pressure: a
//   result must be taken in the cycle it is shown.
module job_fifo_with_indexed_removal_top #(
  parameter int unsigned QUEUE_DEPTH = jfifo_pkg::QueueDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     op_i,
  input  logic [jfifo_pkg::WordW-1:0]    total_length_bits_i,
  input  logic [jfifo_pkg::WordW-1:0]    front_length_bits_i,
  input  logic [jfifo_pkg::WordW-1:0]    back_length_bits_i,
  input  logic [jfifo_pkg::WordW-1:0]    job_quantity_i,
  input  logic [jfifo_pkg::PosW-1:0]     position_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [jfifo_pkg::WordW-1:0]    out_total_length_o,
  output logic [jfifo_pkg::WordW-1:0]    out_front_length_o,
  output logic [jfifo_pkg::WordW-1:0]    out_back_length_o,
  output logic [jfifo_pkg::WordW-1:0]    out_quantity_o,
  output logic [jfifo_pkg::HeldW-1:0]    entries_held_o,
  output logic                           queue_empty_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CmpW = CntW + jfifo_pkg::PosW;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] drop_idx;
  logic            push_ok, drop_ok, pop_ok;
  logic [1:0]      status_d;

  jfifo_pkg::job_rec_t push_rec;
  jfifo_pkg::job_rec_t head_rec;
  jfifo_pkg::job_rec_t rec_chain [QUEUE_DEPTH];

  // Never stalls: one operation per cycle
  assign busy_o = 1'b0;

  assign push_rec = '{total_length: total_length_bits_i,
                      front_length: front_length_bits_i,
                      back_length:  back_length_bits_i,
                      quantity:     job_quantity_i};

  // Operation decode and count update
  always_comb begin
    cnt_d    = cnt_q;
    status_d = jfifo_pkg::ST_DONE;
    push_ok  = 1'b0;
    drop_ok  = 1'b0;
    pop_ok   = 1'b0;
    drop_idx = '0;
    if (start_i) begin
      case (op_i)
        jfifo_pkg::OP_PUSH: begin
          if (cnt_q == CntW'(QUEUE_DEPTH)) begin
            status_d = jfifo_pkg::ST_FULL;
          end else begin
            push_ok = 1'b1;
            cnt_d   = cnt_q + 1'b1;
          end
        end
        jfifo_pkg::OP_POP: begin
          if (cnt_q == '0) begin
            status_d = jfifo_pkg::ST_EMPTY;
          end else begin
            pop_ok  = 1'b1;
            drop_ok = 1'b1;
            cnt_d   = cnt_q - 1'b1;
          end
        end
        jfifo_pkg::OP_REMOVE: begin
          if (CmpW'(position_i) >= CmpW'(cnt_q)) begin
            status_d = jfifo_pkg::ST_EMPTY;
          end else begin
            drop_ok  = 1'b1;
            drop_idx = CntW'(position_i);
            cnt_d    = cnt_q - 1'b1;
          end
        end
        jfifo_pkg::OP_CLEAR: begin
          cnt_d = '0;
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  // Chain of job cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    jfifo_pkg::cell_ctl_t ctl;
    jfifo_pkg::job_rec_t  next_rec;

    assign ctl.load = push_ok && (cnt_q == CntW'(i));
    if (i + 1 < QUEUE_DEPTH) begin : g_mid
      assign ctl.shift = drop_ok && (drop_idx <= CntW'(i));
      assign next_rec  = rec_chain[i+1];
    end else begin : g_last
      assign ctl.shift = 1'b0;
      assign next_rec  = '0;
    end

    jfifo_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .push_rec_i (push_rec),
      .next_rec_i (next_rec),
      .rec_o      (rec_chain[i])
    );
  end

  assign head_rec = rec_chain[0];

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      done_o        <= 1'b0;
      status_o      <= jfifo_pkg::ST_DONE;
      entries_held_o <= '0;
      queue_empty_o <= 1'b1;
    end else begin
      cnt_q  <= cnt_d;
      done_o <= start_i;
      if (start_i) begin
        status_o       <= status_d;
        entries_held_o <= jfifo_pkg::HeldW'(cnt_d);
        queue_empty_o  <= (cnt_d == '0);
      end
    end
  end

  // Popped record, zero unless a pop succeeded
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (pop_ok) begin
        out_total_length_o <= head_rec.total_length;
        out_front_length_o <= head_rec.front_length;
        out_back_length_o  <= head_rec.back_length;
        out_quantity_o     <= head_rec.quantity;
      end else begin
        out_total_length_o <= '0;
        out_front_length_o <= '0;
        out_back_length_o  <= '0;
        out_quantity_o     <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  // Every accepted transaction yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("missing result after accepted transaction");

  // No result without an accepted transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without transaction");

  // Count stays within the queue depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("count exceeds depth");

  // Reported empty flag matches the held count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (queue_empty_o == (cnt_q == '0)))
    else $error("empty flag disagrees with count");

  // A full status is only reported while the queue is full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == jfifo_pkg::ST_FULL) |-> (cnt_q == CntW'(QUEUE_DEPTH)))
    else $error("full status with free slots");
`endif

endmodule
